// File: sv/url_percent_decoder_top_assert.svh
// Assertion macros shared by the URL percent decoder modules.
`ifndef URL_PERCENT_DECODER_TOP_ASSERT_SVH
`define URL_PERCENT_DECODER_TOP_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define UPD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Expression must never be true at a clock edge out of reset.
`define UPD_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error(msg);

`endif

// File: sv/upd_pkg.sv
// Shared types, constants and helper functions of the URL percent decoder.
package upd_pkg;

  // Character codes
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoF   = 8'h66;

  // Value of the letter digit 'a' / 'A'
  localparam logic [3:0] HexAlphaBase = 4'd10;

  // Hard upper bound on decoded bytes per string
  localparam logic [7:0] MaxLen = 8'd255;

  // Reset value of the max_out_len register
  localparam logic [7:0] MaxOutLenReset = 8'd64;

  // Most data bytes one input byte can produce
  localparam int unsigned MaxJobBytes = 3;

  // Work handed from front to back: up to three data bytes, then maybe the end marker
  typedef struct packed {
    logic [MaxJobBytes-1:0][7:0] bytes;
    logic [1:0]                  nbytes;
    logic                        is_end;
  } job_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= Ch0 && c <= Ch9) || (c >= ChLoA && c <= ChLoF) ||
             (c >= ChUpA && c <= ChUpF);
  endfunction

  // Nibble value of a character known to be a hex digit
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c >= ChUpA) begin
      hex_nibble = c[3:0] - 4'd1 + HexAlphaBase;
    end else begin
      hex_nibble = c[3:0];
    end
  endfunction

endpackage

// File: sv/upd_front.sv
// Front end: accepts encoded bytes, tracks escapes and builds output jobs.
module upd_front
  import upd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       full_i,
  output logic       accept_o,
  output logic       push_o,
  output job_t       job_o
);

  typedef enum logic [1:0] {
    PhPlain = 2'd0,
    PhPct   = 2'd1,
    PhDigit = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  job_t       job;
  logic [1:0] n;
  logic       do_plain;
  logic       b_hex;

  assign accept_o = in_valid_i && !full_i;
  assign b_hex    = is_hex(in_byte_i);

  // Classify the byte against the escape state and collect the bytes it releases
  always_comb begin
    job      = '0;
    n        = 2'd0;
    phase_d  = phase_q;
    held_d   = held_q;
    do_plain = 1'b0;

    unique case (phase_q)
      PhPct: begin
        if (b_hex) begin
          held_d  = in_byte_i;
          phase_d = PhDigit;
        end else begin
          job.bytes[n] = ChPct;
          n            = n + 2'd1;
          phase_d      = PhPlain;
          do_plain     = 1'b1;
        end
      end
      PhDigit: begin
        phase_d = PhPlain;
        if (b_hex) begin
          job.bytes[n] = {hex_nibble(held_q), hex_nibble(in_byte_i)};
          n            = n + 2'd1;
        end else begin
          job.bytes[n] = ChPct;
          n            = n + 2'd1;
          job.bytes[n] = held_q;
          n            = n + 2'd1;
          do_plain     = 1'b1;
        end
      end
      default: begin
        phase_d  = PhPlain;
        do_plain = 1'b1;
      end
    endcase

    // Ordinary byte handling
    if (do_plain) begin
      if (in_byte_i == ChPct) begin
        phase_d = PhPct;
      end else if (in_byte_i == ChPlus) begin
        job.bytes[n] = ChSpace;
        n            = n + 2'd1;
      end else begin
        job.bytes[n] = in_byte_i;
        n            = n + 2'd1;
      end
    end

    // Flush a cut escape on the last byte
    if (in_last_i) begin
      if (phase_d == PhPct) begin
        job.bytes[n] = ChPct;
        n            = n + 2'd1;
      end else if (phase_d == PhDigit) begin
        job.bytes[n] = ChPct;
        n            = n + 2'd1;
        job.bytes[n] = held_d;
        n            = n + 2'd1;
      end
      phase_d    = PhPlain;
      job.is_end = 1'b1;
    end

    job.nbytes = n;
  end

  assign job_o  = job;
  assign push_o = accept_o && ((n != 2'd0) || in_last_i);

  // Escape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPlain;
      held_q  <= '0;
    end else if (accept_o) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// File: sv/upd_queue.sv
// Small job queue between front and back.
`include "url_percent_decoder_top_assert.svh"
module upd_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  `UPD_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o && !pop_i, "queue overflow")
  `UPD_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !valid_o, "pop from empty queue")
  `UPD_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= FullCnt, "queue count out of range")

endmodule

// File: sv/upd_back.sv
// Back end: drains jobs one beat per unstalled cycle, caps length, drives the output register.
`include "url_percent_decoder_top_assert.svh"
module upd_back
  import upd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] cap_i,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       is_data_o,
  output logic [7:0] out_len_o,
  output logic       out_last_o
);

  logic [7:0] count_q, count_d;
  logic [1:0] sel_q, sel_d;
  logic       ovalid_q;
  logic [7:0] obyte_q, olen_q;
  logic       odata_q, olast_q;

  logic       can_load, load, has_data;
  logic [7:0] nbyte, nlen;
  logic       ndata, nlast;
  logic [1:0] sel_inc;

  assign can_load = !ovalid_q || !out_stall_i;
  assign has_data = (sel_q < job_i.nbytes) && (count_q < cap_i);
  assign sel_inc  = sel_q + 2'd1;

  // Pick the next beat of the head job
  always_comb begin
    pop_o   = 1'b0;
    load    = 1'b0;
    sel_d   = sel_q;
    count_d = count_q;
    nbyte   = '0;
    ndata   = 1'b0;
    nlen    = count_q;
    nlast   = 1'b0;
    if (job_valid_i) begin
      if (has_data) begin
        if (can_load) begin
          load    = 1'b1;
          nbyte   = job_i.bytes[sel_q];
          ndata   = 1'b1;
          nlen    = count_q + 8'd1;
          count_d = count_q + 8'd1;
          if ((sel_inc == job_i.nbytes) && !job_i.is_end) begin
            pop_o = 1'b1;
            sel_d = '0;
          end else begin
            sel_d = sel_inc;
          end
        end
      end else if (job_i.is_end) begin
        // end marker carries the string length
        if (can_load) begin
          load    = 1'b1;
          nlast   = 1'b1;
          count_d = '0;
          pop_o   = 1'b1;
          sel_d   = '0;
        end
      end else begin
        // remaining bytes dropped by the cap
        pop_o = 1'b1;
        sel_d = '0;
      end
    end
  end

  // Control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sel_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      sel_q   <= sel_d;
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      obyte_q <= nbyte;
      odata_q <= ndata;
      olen_q  <= nlen;
      olast_q <= nlast;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign is_data_o   = odata_q;
  assign out_len_o   = olen_q;
  assign out_last_o  = olast_q;

  `UPD_ASSERT(a_len_in_cap, clk_i, rst_ni, (ovalid_q && odata_q) |-> (olen_q != 8'd0 && olen_q <= cap_i), "data beat beyond cap")
  `UPD_ASSERT(a_sel_range, clk_i, rst_ni, job_valid_i |-> (sel_q <= job_i.nbytes), "byte select past job")
  `UPD_ASSERT(a_sel_idle, clk_i, rst_ni, !job_valid_i |-> (sel_q == 2'd0), "byte select left over")

endmodule

// File: sv/url_percent_decoder_top.sv
// Top level of the URL percent decoder: config register, front, job queue and back.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+------------------------------------
//  in       | in  | in_valid_i / in_stall_o | in_byte_i, in_last_i
//  out      | out | out_valid_o/out_stall_i | out_byte_o, is_data_o, out_len_o,
//           |     |                         | out_last_o
//  apb      | in  | psel/penable/pready     | pwrite, paddr, pwdata, prdata
//
// One input byte is accepted per cycle while the job queue has room.
// The back end sends at most one result beat per cycle; a byte that releases k data
// bytes and maybe an end marker holds it for each of those beats, bytes past the
// cap are discarded together, and out_stall_i holds it longer.
// A result passes from its accepted byte through the queue write, then the
// output register, and can be taken at the next edge while out_stall_i is low.
// Reset empties the queue and clears control state; max_out_len returns to 64.
// in_stall_o rises only when the queue is full.
`include "url_percent_decoder_top_assert.svh"
module url_percent_decoder_top
  import upd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        is_data_o,
  output logic [7:0]  out_len_o,
  output logic        out_last_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] AddrMaxOutLen = 2'd0;

  logic [7:0] max_out_len_q;
  logic [7:0] cap;
  logic       cfg_wr;
  logic       accept, push, full, job_valid, pop;
  job_t       job_in, job_head;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == AddrMaxOutLen) ? {24'd0, max_out_len_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_out_len_q <= MaxOutLenReset;
    end else if (cfg_wr && (paddr == AddrMaxOutLen)) begin
      max_out_len_q <= pwdata[7:0];
    end
  end

  assign cap = (max_out_len_q > MaxLen) ? MaxLen : max_out_len_q;

  assign in_stall_o = full;

  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .full_i     (full),
    .accept_o   (accept),
    .push_o     (push),
    .job_o      (job_in)
  );

  upd_queue #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .rdata_o (job_head)
  );

  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .is_data_o   (is_data_o),
    .out_len_o   (out_len_o),
    .out_last_o  (out_last_o)
  );

  `UPD_ASSERT(a_push_needs_accept, clk_i, rst_ni, push |-> accept, "job pushed without accepted byte")
  `UPD_ASSERT(a_last_pushes, clk_i, rst_ni, (accept && in_last_i) |-> push, "last byte produced no job")
  `UPD_ASSERT_NEVER(a_out_known, clk_i, rst_ni, out_valid_o && $isunknown(out_byte_o), "unknown out byte")

endmodule
